/* hdl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants of the serial message deframer.
// ----------------------------------------------------------------------------
package smd_pkg;

    // Result event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PAYLOAD   = 3'd1;
    localparam logic [2:0] EV_EMPTY     = 3'd2;
    localparam logic [2:0] EV_HANDSHAKE = 3'd3;
    localparam logic [2:0] EV_UNKNOWN   = 3'd4;

    // Handshake reply byte values
    localparam logic [1:0] REPLY_OFF = 2'd0;
    localparam logic [1:0] REPLY_ON  = 2'd2;

    // Header constants
    localparam logic [7:0]  SYNC_WORD [4] = '{8'h33, 8'h32, 8'h42, 8'h4C};
    localparam logic [31:0] TYPE_MLTI = 32'h4D4C5449;
    localparam logic [31:0] TYPE_USER = 32'h55534552;

    // Last header byte position (header is eight bytes)
    localparam logic [2:0] POS_SYNC_END = 3'd4;
    localparam logic [2:0] POS_LAST     = 3'd7;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_SHAKE   = 5'b00010,
        PH_LEN_LO  = 5'b00100,
        PH_LEN_HI  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data;
        logic        last;
        logic [15:0] message_length;
        logic        send_reply;
        logic [1:0]  reply_value;
        logic        connected;
    } t_result;

endpackage

/* hdl/smd_frame.sv */
// ----------------------------------------------------------------------------
// smd_frame
// Framing state of the deframer: header hunt, type decode, length capture
// and payload count. Produces the result of the item presented this cycle
// and updates its state when that item is accepted.
// ----------------------------------------------------------------------------
module smd_frame
    import smd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic       i_link_enabled,
    output t_result    o_result
);

    t_phase      r_phase,       n_phase;
    logic [2:0]  r_match_pos,   n_match_pos;
    logic [23:0] r_type_word,   n_type_word;
    logic [15:0] r_pay_len,     n_pay_len;
    logic [15:0] r_pay_off,     n_pay_off;
    logic        r_peer_up,     n_peer_up;

    logic [31:0] type_full;
    logic [15:0] off_inc;
    logic [15:0] len_full;

    assign type_full = {r_type_word, i_rx_byte};
    assign off_inc   = r_pay_off + 16'd1;
    assign len_full  = {i_rx_byte, r_pay_len[7:0]};

    always_comb begin
        n_phase     = r_phase;
        n_match_pos = r_match_pos;
        n_type_word = r_type_word;
        n_pay_len   = r_pay_len;
        n_pay_off   = r_pay_off;
        n_peer_up   = r_peer_up;
        o_result    = '0;

        if (i_mode) begin
            // Link lost only drops the peer; framing carries on.
            n_peer_up = 1'b0;
        end else begin
            case (r_phase)
                PH_SHAKE: begin
                    n_peer_up           = (i_rx_byte != 8'd0);
                    o_result.event_res  = EV_HANDSHAKE;
                    o_result.send_reply = n_peer_up;
                    n_phase             = PH_HUNT;
                end
                PH_LEN_LO: begin
                    n_pay_len = {8'd0, i_rx_byte};
                    n_phase   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_pay_len = len_full;
                    n_pay_off = 16'd0;
                    if (len_full == 16'd0) begin
                        o_result.event_res = EV_EMPTY;
                        o_result.last      = 1'b1;
                        n_phase            = PH_HUNT;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_result.event_res = EV_PAYLOAD;
                    o_result.data      = i_rx_byte;
                    n_pay_off          = off_inc;
                    if (off_inc >= r_pay_len) begin
                        o_result.last = 1'b1;
                        n_phase       = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (r_match_pos < POS_SYNC_END) begin
                        n_match_pos = (i_rx_byte == SYNC_WORD[r_match_pos[1:0]]) ?
                                      r_match_pos + 3'd1 : 3'd0;
                    end else begin
                        // Only the four type bytes of this header reach the compare.
                        n_type_word = type_full[23:0];
                        if (r_match_pos != POS_LAST) begin
                            n_match_pos = r_match_pos + 3'd1;
                        end else begin
                            n_match_pos = 3'd0;
                            if (type_full == TYPE_MLTI) begin
                                n_phase = PH_SHAKE;
                            end else if (type_full == TYPE_USER) begin
                                n_phase = PH_LEN_LO;
                            end else begin
                                o_result.event_res = EV_UNKNOWN;
                            end
                        end
                    end
                end
            endcase
        end

        o_result.message_length = n_pay_len;
        o_result.reply_value    = i_link_enabled ? REPLY_ON : REPLY_OFF;
        o_result.connected      = i_link_enabled & n_peer_up;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_match_pos <= 3'd0;
            r_type_word <= 24'd0;
            r_pay_len   <= 16'd0;
            r_pay_off   <= 16'd0;
            r_peer_up   <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_match_pos <= n_match_pos;
            r_type_word <= n_type_word;
            r_pay_len   <= n_pay_len;
            r_pay_off   <= n_pay_off;
            r_peer_up   <= n_peer_up;
        end
    end

endmodule

/* hdl/serial_message_deframer_core.sv */
// ----------------------------------------------------------------------------
// serial_message_deframer_core
// Serial message deframer: header match, handshake and user payload output.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake                  | Payload
// in       | input     | i_in_valid / o_in_stall    | mode, rx_byte
// out      | output    | o_out_valid / i_out_stall  | event_res .. connected
// cfg      | input     | i_cfg_we (no wait)         | link_enabled
//
// One result per transfer in, one transfer per cycle sustained unless the
// output is stalled. The framing logic feeds the output register.
// A skid register behind the output register takes one more transfer
// while the output is stalled; o_in_stall rises only when it is full.
// Synchronous active-low reset clears framing state, link_enabled and
// both valid flags.
// ----------------------------------------------------------------------------
module serial_message_deframer_core
    import smd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_mode,
    input  logic [7:0]  i_in_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_event_res,
    output logic [7:0]  o_out_data,
    output logic        o_out_last,
    output logic [15:0] o_out_message_length,
    output logic        o_out_send_reply,
    output logic [1:0]  o_out_reply_value,
    output logic        o_out_connected
);

    logic    r_link_enabled;
    logic    in_accept;
    t_result new_result;
    t_result r_out,  r_skid;
    logic    r_out_valid, r_skid_valid;

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            r_link_enabled <= i_cfg_wdata;
        end
    end

    smd_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_mode         (i_in_mode),
        .i_rx_byte      (i_in_rx_byte),
        .i_link_enabled (r_link_enabled),
        .o_result       (new_result)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_out_stall) begin
            if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end else begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_out_stall) begin
            if (in_accept) begin
                r_skid <= new_result;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_accept) begin
            r_out <= new_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_event_res      = r_out.event_res;
    assign o_out_data           = r_out.data;
    assign o_out_last           = r_out.last;
    assign o_out_message_length = r_out.message_length;
    assign o_out_send_reply     = r_out.send_reply;
    assign o_out_reply_value    = r_out.reply_value;
    assign o_out_connected      = r_out.connected;

endmodule

/* hdl/smd_checker.sv */
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks on the serial message deframer, bound to the top level.
// ----------------------------------------------------------------------------
module smd_checker
    import smd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_out_event_res,
    input logic [7:0]  o_out_data,
    input logic        o_out_last,
    input logic [15:0] o_out_message_length,
    input logic [1:0]  o_out_reply_value,
    input logic        o_out_connected
);

    // A stalled result must hold until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_event_res)
            && $stable(o_out_data) && $stable(o_out_last)
            && $stable(o_out_message_length))
        else $error("stalled result changed");

    // The input side stalls only once the output has been held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // Data is carried only by payload results.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_event_res != EV_PAYLOAD) |-> o_out_data == 8'd0)
        else $error("data set outside a payload result");

    // The last mark belongs to a payload byte or an empty message.
    a_last_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last |->
            (o_out_event_res == EV_PAYLOAD) || (o_out_event_res == EV_EMPTY))
        else $error("last mark on a non-payload result");

    // A connected link always reports the enabled reply value.
    a_connected_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_connected |-> o_out_reply_value == REPLY_ON)
        else $error("connected without enabled reply value");

endmodule

bind serial_message_deframer_core smd_checker u_smd_checker (.*);

/* verif/serial_message_deframer_core_test.sv */
// ----------------------------------------------------------------------------
// serial_message_deframer_core_test
// Self-checking bench for the deframer. Whole framed messages (handshakes,
// user payloads, unknown types, broken headers, noise and link-lost events)
// are fed through the input channel. A bit-accurate copy of the framing
// state predicts each result, and every output transfer is compared field
// by field, under several link settings and flow-control mixes.
// ----------------------------------------------------------------------------
module serial_message_deframer_core_test
    import smd_pkg::*;
();

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_rx_item;

    localparam int ITEMS_PER_ROUND = 467;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_in_mode = 1'b0;
    logic [7:0]  i_in_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_out_event_res;
    logic [7:0]  o_out_data;
    logic        o_out_last;
    logic [15:0] o_out_message_length;
    logic        o_out_send_reply;
    logic [1:0]  o_out_reply_value;
    logic        o_out_connected;

    serial_message_deframer_core i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_in_mode            (i_in_mode),
        .i_in_rx_byte         (i_in_rx_byte),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_event_res      (o_out_event_res),
        .o_out_data           (o_out_data),
        .o_out_last           (o_out_last),
        .o_out_message_length (o_out_message_length),
        .o_out_send_reply     (o_out_send_reply),
        .o_out_reply_value    (o_out_reply_value),
        .o_out_connected      (o_out_connected)
    );

    always #2 i_clk = ~i_clk;

    t_rx_item rx_pending [$];
    t_result  frame_results_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int lost_pct = 0;
    int items_queued = 0;
    int items_taken = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int ev_seen [8];

    // Predicted framing state and the predicted copy of the link register.
    logic        link_en = 1'b0;
    t_phase      rx_phase = PH_HUNT;
    logic [2:0]  hdr_pos = 3'd0;
    logic [31:0] type_shift = 32'h0;
    logic [15:0] msg_len = 16'h0;
    logic [15:0] msg_count = 16'h0;
    logic        peer_up = 1'b0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
        end
    endtask

    function automatic t_result deframe_step(input logic mode, input logic [7:0] b);
        t_result    r;
        logic [2:0] pos;
        r = '0;
        if (mode) begin
            peer_up = 1'b0;
        end else begin
            case (rx_phase)
                PH_SHAKE: begin
                    peer_up = (b != 8'h00);
                    r.event_res = EV_HANDSHAKE;
                    r.send_reply = peer_up;
                    rx_phase = PH_HUNT;
                end
                PH_LEN_LO: begin
                    msg_len = {8'h00, b};
                    rx_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    msg_len[15:8] = b;
                    msg_count = 16'h0;
                    if (msg_len == 16'h0) begin
                        r.event_res = EV_EMPTY;
                        r.last = 1'b1;
                        rx_phase = PH_HUNT;
                    end else begin
                        rx_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    r.event_res = EV_PAYLOAD;
                    r.data = b;
                    msg_count = msg_count + 16'd1;
                    if (msg_count >= msg_len) begin
                        r.last = 1'b1;
                        rx_phase = PH_HUNT;
                    end
                end
                default: begin
                    pos = hdr_pos;
                    rx_phase = PH_HUNT;
                    if (pos < POS_SYNC_END) begin
                        hdr_pos = (b == SYNC_WORD[pos[1:0]]) ? pos + 3'd1 : 3'd0;
                    end else begin
                        type_shift = {type_shift[23:0], b};
                        if (pos < POS_LAST) begin
                            hdr_pos = pos + 3'd1;
                        end else begin
                            hdr_pos = 3'd0;
                            if (type_shift == TYPE_MLTI) rx_phase = PH_SHAKE;
                            else if (type_shift == TYPE_USER) rx_phase = PH_LEN_LO;
                            else r.event_res = EV_UNKNOWN;
                        end
                    end
                end
            endcase
        end
        r.message_length = msg_len;
        r.reply_value = link_en ? REPLY_ON : REPLY_OFF;
        r.connected = link_en & peer_up;
        return r;
    endfunction

    // Sender: holds a stalled transfer, otherwise offers the next pending item.
    always @(posedge i_clk) begin : drive
        t_rx_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                frame_results_due.push_back(deframe_step(i_in_mode, i_in_rx_byte));
                items_taken++;
            end
            if (rx_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = rx_pending.pop_front();
                i_in_valid <= 1'b1;
                i_in_mode <= nxt.mode;
                i_in_rx_byte <= nxt.rx_byte;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, and each output transfer checked in order.
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (o_out_valid && !i_out_stall) begin
                if (frame_results_due.size() == 0) begin
                    report_mismatch("result with nothing due, event_res", o_out_event_res, 0);
                end else begin
                    want = frame_results_due.pop_front();
                    results_checked++;
                    ev_seen[want.event_res]++;
                    if (o_out_event_res !== want.event_res)
                        report_mismatch("event_res", o_out_event_res, want.event_res);
                    if (o_out_data !== want.data)
                        report_mismatch("data", o_out_data, want.data);
                    if (o_out_last !== want.last)
                        report_mismatch("last", o_out_last, want.last);
                    if (o_out_message_length !== want.message_length)
                        report_mismatch("message_length", o_out_message_length,
                                        want.message_length);
                    if (o_out_send_reply !== want.send_reply)
                        report_mismatch("send_reply", o_out_send_reply, want.send_reply);
                    if (o_out_reply_value !== want.reply_value)
                        report_mismatch("reply_value", o_out_reply_value, want.reply_value);
                    if (o_out_connected !== want.connected)
                        report_mismatch("connected", o_out_connected, want.connected);
                end
            end
        end
    end

    task automatic push_item(input logic mode, input logic [7:0] b);
        t_rx_item it;
        it.mode = mode;
        it.rx_byte = b;
        rx_pending.push_back(it);
        items_queued++;
    endtask

    // A link-lost event may slip in ahead of any byte; it must not upset framing.
    task automatic push_byte(input logic [7:0] b);
        if (lost_pct > 0 && $urandom_range(0, 99) < lost_pct) push_item(1'b1, 8'($urandom));
        push_item(1'b0, b);
    endtask

    task automatic push_header(input logic [31:0] type_code);
        for (int i = 0; i < 4; i++) push_byte(SYNC_WORD[i]);
        for (int i = 3; i >= 0; i--) push_byte(type_code[8*i +: 8]);
    endtask

    task automatic push_message();
        int          sel;
        int          len;
        logic [31:0] odd_type;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            push_header(TYPE_MLTI);
            push_byte(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        end else if (sel < 75) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) len = 0;
            else if (sel < 88) len = $urandom_range(1, 12);
            else if (sel < 98) len = $urandom_range(13, 64);
            else len = $urandom_range(200, 300);
            push_header(TYPE_USER);
            push_byte(len[7:0]);
            push_byte(len[15:8]);
            for (int i = 0; i < len; i++) push_byte(8'($urandom));
        end else if (sel < 85) begin
            // Mostly near misses of the known type words, now and then anything.
            odd_type = $urandom_range(0, 1) ? TYPE_MLTI : TYPE_USER;
            odd_type = odd_type ^ (32'h1 << $urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0) odd_type = $urandom;
            push_header(odd_type);
        end else if (sel < 93) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end else begin
            // Header that breaks off partway through the sync bytes.
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) push_byte(SYNC_WORD[i]);
            push_byte(8'($urandom));
        end
    endtask

    task automatic write_link(input logic value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        link_en = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued item has been taken and every result checked.
    task automatic settle();
        do @(posedge i_clk);
        while (rx_pending.size() > 0 || i_in_valid || frame_results_due.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int round = 0; round < 3; round++) begin
            case (round)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_link(round != 1);
            if (round == 0) begin
                lost_pct = 0;
                // Zero handshake byte, empty user message, link lost, unknown type.
                push_header(TYPE_MLTI);
                push_byte(8'h00);
                push_header(TYPE_USER);
                push_byte(8'h00);
                push_byte(8'h00);
                push_item(1'b1, 8'hFF);
                push_header(32'hFF00A55A);
            end
            lost_pct = 3;
            while (items_queued < (round + 1) * ITEMS_PER_ROUND) push_message();
            settle();
        end
        if (frame_results_due.size() > 0)
            report_mismatch("results never delivered", 0, frame_results_due.size());
        $display("Covered %0d input transfers and %0d checked results",
                 items_taken, results_checked);
        $display("over link settings 1, 0, 1.");
        $display("Seen: %0d payload bytes, %0d empty messages, %0d handshakes, %0d unknown types.",
                 ev_seen[EV_PAYLOAD], ev_seen[EV_EMPTY], ev_seen[EV_HANDSHAKE],
                 ev_seen[EV_UNKNOWN]);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d items pending and %0d results due.",
                 rx_pending.size(), frame_results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
hdl/smd_pkg.sv
hdl/smd_frame.sv
hdl/serial_message_deframer_core.sv
hdl/smd_checker.sv
verif/serial_message_deframer_core_test.sv
